### rtl/core/capreg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// capreg_pkg
// Shared types and codes for the capability region checker.
// ----------------------------------------------------------------------------
package capreg_pkg;

   localparam int KIND_W  = 4;
   localparam int COORD_W = 32;
   localparam int CODE_W  = 3;

   typedef enum logic [1:0] {
      ACT_GRANT = 2'd0,
      ACT_CHECK = 2'd1,
      ACT_CLEAR = 2'd2
   } action_type;

   typedef enum logic [CODE_W-1:0] {
      RES_GRANTED = 3'd0,
      RES_FULL    = 3'd1,
      RES_DENIED  = 3'd2,
      RES_ALLOWED = 3'd3,
      RES_CLEARED = 3'd4
   } result_type;

   // One stored capability: kind plus inclusive rectangle.
   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [COORD_W-1:0] x_low;
      logic [COORD_W-1:0] x_high;
      logic [COORD_W-1:0] y_low;
      logic [COORD_W-1:0] y_high;
   } entry_type;

endpackage

### rtl/core/capability_region_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// capability_region_checker
// Per-process capability tables with grant, point check and clear.
// ----------------------------------------------------------------------------
// Grant, clear and unused actions pass through the dispatch and result states
// after the input transfer; a check also scans the slot's stored entries, as
// many as its entry count, stopping early on a hit, with one entry memory read
// per cycle into one shared compare unit. The block takes no new request until
// the result is loaded into the output register and it is back in idle, and a
// result waits while the previous one still sits in the output register.
// Reset clears the per-slot count valid bits at once, so all tables read
// empty; the entry memory itself is not cleared.
module capability_region_checker
   import capreg_pkg::*;
#(
   parameter int NUM_PROCESSES = 16,
   parameter int MAX_CAPS      = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // process_slot[3:0], cap_kind[7:4], x_low[39:8], x_high[71:40],
   // y_low[103:72], y_high[135:104], probe_x[167:136], probe_y[199:168]
   input  logic [199:0] req_tdata,
   // action[1:0]
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // result_code[2:0]
   output logic [7:0]   rsp_tdata
);

   localparam int TOTAL    = NUM_PROCESSES * MAX_CAPS;
   localparam int SLOT_W   = (NUM_PROCESSES > 1) ? $clog2(NUM_PROCESSES) : 1;
   localparam int ENTRY_AW = (TOTAL > 1) ? $clog2(TOTAL) : 1;
   localparam int CNT_W    = $clog2(MAX_CAPS + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SCAN,
      ST_RESP
   } state_type;

   // memories
   entry_type        ent_mem [TOTAL];
   logic [CNT_W-1:0] cnt_mem [NUM_PROCESSES];

   // request field views
   logic [3:0]         rq_slot;
   logic [SLOT_W-1:0]  rq_slot_idx;
   logic               rq_in_range;
   entry_type          rq_entry;

   state_type           state_ff, state_in;
   logic                rsp_vld_ff, rsp_vld_in;
   result_type          rsp_code_ff, rsp_code_in;
   result_type          code_ff, code_in;
   logic [1:0]          action_ff, action_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic                in_range_ff, in_range_in;
   logic [ENTRY_AW-1:0] base_ff, base_in;
   entry_type           req_ent_ff, req_ent_in;
   logic [COORD_W-1:0]  probe_x_ff, probe_x_in;
   logic [COORD_W-1:0]  probe_y_ff, probe_y_in;
   logic [CNT_W-1:0]    n_ff, n_in;
   logic [CNT_W-1:0]    issue_ff, issue_in;
   logic                pend_ff, pend_in;
   logic [NUM_PROCESSES-1:0] cnt_vld_ff, cnt_vld_in;

   logic [CNT_W-1:0]    cnt_rd_ff;
   entry_type           ent_rd_ff;
   logic [ENTRY_AW-1:0] ent_rd_addr;

   logic                ent_we;
   logic [ENTRY_AW-1:0] ent_wr_addr;
   logic                cnt_we;
   logic [CNT_W-1:0]    cnt_wr_data;
   logic [CNT_W-1:0]    cur_cnt;
   logic                hit;

   assign rq_slot     = req_tdata[3:0];
   assign rq_slot_idx = SLOT_W'(rq_slot);
   assign rq_in_range = (32'(rq_slot) < 32'(NUM_PROCESSES));
   assign rq_entry.kind   = req_tdata[7:4];
   assign rq_entry.x_low  = req_tdata[39:8];
   assign rq_entry.x_high = req_tdata[71:40];
   assign rq_entry.y_low  = req_tdata[103:72];
   assign rq_entry.y_high = req_tdata[135:104];

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {5'd0, rsp_code_ff};

   // stale counts of a cleared slot read as zero
   assign cur_cnt = cnt_vld_ff[slot_ff] ? cnt_rd_ff : '0;

   assign ent_rd_addr = ENTRY_AW'(base_ff + ENTRY_AW'(issue_ff));
   assign ent_wr_addr = ENTRY_AW'(base_ff + ENTRY_AW'(cur_cnt));
   assign cnt_wr_data = CNT_W'(cur_cnt + 1'b1);

   // shared compare unit, one stored entry per cycle
   assign hit = (ent_rd_ff.kind == req_ent_ff.kind) &&
                (probe_x_ff >= ent_rd_ff.x_low) && (probe_x_ff <= ent_rd_ff.x_high) &&
                (probe_y_ff >= ent_rd_ff.y_low) && (probe_y_ff <= ent_rd_ff.y_high);

   always_comb begin
      state_in    = state_ff;
      rsp_vld_in  = rsp_vld_ff;
      rsp_code_in = rsp_code_ff;
      code_in     = code_ff;
      action_in   = action_ff;
      slot_in     = slot_ff;
      in_range_in = in_range_ff;
      base_in     = base_ff;
      req_ent_in  = req_ent_ff;
      probe_x_in  = probe_x_ff;
      probe_y_in  = probe_y_ff;
      n_in        = n_ff;
      issue_in    = issue_ff;
      pend_in     = pend_ff;
      cnt_vld_in  = cnt_vld_ff;
      ent_we      = 1'b0;
      cnt_we      = 1'b0;

      if (rsp_vld_ff && rsp_tready) begin
         rsp_vld_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               action_in   = req_tuser;
               slot_in     = rq_slot_idx;
               in_range_in = rq_in_range;
               base_in     = ENTRY_AW'(32'(rq_slot_idx) * MAX_CAPS);
               req_ent_in  = rq_entry;
               probe_x_in  = req_tdata[167:136];
               probe_y_in  = req_tdata[199:168];
               state_in    = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            state_in = ST_RESP;
            case (action_ff)
               ACT_GRANT: begin
                  if (!in_range_ff || (32'(cur_cnt) >= 32'(MAX_CAPS))) begin
                     code_in = RES_FULL;
                  end else begin
                     ent_we              = 1'b1;
                     cnt_we              = 1'b1;
                     cnt_vld_in[slot_ff] = 1'b1;
                     code_in             = RES_GRANTED;
                  end
               end
               ACT_CHECK: begin
                  if (!in_range_ff) begin
                     code_in = RES_DENIED;
                  end else begin
                     n_in     = cur_cnt;
                     issue_in = '0;
                     pend_in  = 1'b0;
                     state_in = ST_SCAN;
                  end
               end
               ACT_CLEAR: begin
                  if (in_range_ff) begin
                     cnt_vld_in[slot_ff] = 1'b0;
                  end
                  code_in = RES_CLEARED;
               end
               default: begin
                  code_in = RES_DENIED;
               end
            endcase
         end
         ST_SCAN: begin
            // each read issues in the cycle before its compare
            if (pend_ff && hit) begin
               code_in  = RES_ALLOWED;
               state_in = ST_RESP;
            end else if (issue_ff >= n_ff) begin
               code_in  = RES_DENIED;
               state_in = ST_RESP;
            end else begin
               issue_in = CNT_W'(issue_ff + 1'b1);
               pend_in  = 1'b1;
            end
         end
         ST_RESP: begin
            if (!rsp_vld_ff || rsp_tready) begin
               rsp_vld_in  = 1'b1;
               rsp_code_in = code_ff;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         rsp_vld_ff <= 1'b0;
         pend_ff    <= 1'b0;
         cnt_vld_ff <= '0;
      end else begin
         state_ff   <= state_in;
         rsp_vld_ff <= rsp_vld_in;
         pend_ff    <= pend_in;
         cnt_vld_ff <= cnt_vld_in;
      end
      rsp_code_ff <= rsp_code_in;
      code_ff     <= code_in;
      action_ff   <= action_in;
      slot_ff     <= slot_in;
      in_range_ff <= in_range_in;
      base_ff     <= base_in;
      req_ent_ff  <= req_ent_in;
      probe_x_ff  <= probe_x_in;
      probe_y_ff  <= probe_y_in;
      n_ff        <= n_in;
      issue_ff    <= issue_in;
   end

   // count memory: read at the incoming slot, written on a grant
   always_ff @(posedge clock) begin
      cnt_rd_ff <= cnt_mem[rq_slot_idx];
      if (cnt_we) begin
         cnt_mem[slot_ff] <= cnt_wr_data;
      end
   end

   // entry memory: one read and one write port
   always_ff @(posedge clock) begin
      ent_rd_ff <= ent_mem[ent_rd_addr];
      if (ent_we) begin
         ent_mem[ent_wr_addr] <= req_ent_ff;
      end
   end

endmodule

### sim/region_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// region_result_checker
// Watches both streams of the capability region checker, keeps its own
// copy of the per-slot capability tables, predicts the result code of every
// request transfer and compares it with the result transfers in order.
// ----------------------------------------------------------------------------
module region_result_checker
   import capreg_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   // process_slot[3:0], cap_kind[7:4], x_low[39:8], x_high[71:40],
   // y_low[103:72], y_high[135:104], probe_x[167:136], probe_y[199:168]
   input  logic [199:0] req_tdata,
   // action[1:0]
   input  logic [1:0]   req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   // result_code[2:0]
   input  logic [7:0]   rsp_tdata,
   output int           fail_count,
   output int           pending_count
);

   localparam int SLOT_COUNT    = 16;
   localparam int CAPS_PER_SLOT = 8;

   entry_type   cap_table [SLOT_COUNT][CAPS_PER_SLOT];
   int unsigned cap_count [SLOT_COUNT];
   result_type  expected_codes [$];

   // Applies one request to the table copy and returns its result code.
   function automatic result_type apply_request(input logic [1:0] act,
                                                input logic [3:0] slot,
                                                input entry_type cap,
                                                input logic [COORD_W-1:0] px,
                                                input logic [COORD_W-1:0] py);
      result_type code;
      entry_type  held;
      code = RES_DENIED;
      case (act)
         ACT_GRANT: begin
            if (slot >= SLOT_COUNT || cap_count[slot] >= CAPS_PER_SLOT) begin
               code = RES_FULL;
            end else begin
               cap_table[slot][cap_count[slot]] = cap;
               cap_count[slot] = cap_count[slot] + 1;
               code = RES_GRANTED;
            end
         end
         ACT_CHECK: begin
            if (slot < SLOT_COUNT) begin
               for (int i = 0; i < cap_count[slot]; i++) begin
                  held = cap_table[slot][i];
                  if (held.kind == cap.kind &&
                      px >= held.x_low && px <= held.x_high &&
                      py >= held.y_low && py <= held.y_high)
                     code = RES_ALLOWED;
               end
            end
         end
         ACT_CLEAR: begin
            // only the count goes back to zero, old entries stay stored
            if (slot < SLOT_COUNT)
               cap_count[slot] = 0;
            code = RES_CLEARED;
         end
         default: code = RES_DENIED;
      endcase
      return code;
   endfunction

   always @(posedge clock) begin
      entry_type  cap;
      result_type want;
      if (reset) begin
         foreach (cap_count[s])
            cap_count[s] = 0;
         expected_codes.delete();
         fail_count    <= 0;
         pending_count <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            cap.kind   = req_tdata[7:4];
            cap.x_low  = req_tdata[39:8];
            cap.x_high = req_tdata[71:40];
            cap.y_low  = req_tdata[103:72];
            cap.y_high = req_tdata[135:104];
            expected_codes.push_back(apply_request(req_tuser, req_tdata[3:0], cap,
                                                   req_tdata[167:136],
                                                   req_tdata[199:168]));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_codes.size() == 0) begin
               $display("%0t ns: unexpected result transfer, expected none, got %0d",
                        $time, rsp_tdata[2:0]);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_codes.pop_front();
               if (rsp_tdata[2:0] !== want) begin
                  $display("%0t ns: result_code mismatch, expected %0d (%s), got %0d",
                           $time, want, want.name(), rsp_tdata[2:0]);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending_count <= expected_codes.size();
      end
   end

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives grant, check, clear and unused requests into the capability region
// checker with random gaps and result back-pressure; the result checker
// beside the block predicts and compares every result code.
// ----------------------------------------------------------------------------
module tb_top;
   import capreg_pkg::*;

   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int HOLD_CYCLES  = 200;
   localparam int DRAIN_CYCLES = 30;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [199:0] req_tdata;
   logic [1:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [7:0]   rsp_tdata;

   int fail_count;
   int pending_count;
   int send_idle_pct;
   int recv_idle_pct;
   int cycle_count;
   bit hold_request;
   bit hold_done;

   // last grant per slot, used to aim checks at stored rectangles
   logic [3:0]  last_kind [16];
   logic [31:0] last_xl [16];
   logic [31:0] last_xh [16];
   logic [31:0] last_yl [16];
   logic [31:0] last_yh [16];

   capability_region_checker uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   region_result_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("capability_region_checker test failed");
         $finish;
      end
   end

   // Result side: random stalls, or one long hold-off when requested.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request && !hold_done) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // Uniform pick in [lo..hi]; an empty range gives lo.
   function automatic logic [31:0] pick_between(input logic [31:0] lo,
                                                input logic [31:0] hi);
      logic [63:0] span;
      if (lo > hi)
         return lo;
      span = {32'd0, hi} - {32'd0, lo} + 64'd1;
      return lo + 32'(({$urandom, $urandom}) % span);
   endfunction

   task automatic send_item(input logic [1:0] act, input logic [3:0] slot,
                            input logic [3:0] kind,
                            input logic [31:0] xl, input logic [31:0] xh,
                            input logic [31:0] yl, input logic [31:0] yh,
                            input logic [31:0] px, input logic [31:0] py);
      int gap;
      gap = 0;
      while ($urandom_range(0, 99) < send_idle_pct)
         gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {py, px, yh, yl, xh, xl, kind, slot};
      do @(posedge clock); while (!req_tready);
      if (act == ACT_GRANT) begin
         last_kind[slot] = kind;
         last_xl[slot]   = xl;
         last_xh[slot]   = xh;
         last_yl[slot]   = yl;
         last_yh[slot]   = yh;
      end
   endtask

   // Mostly grants and aimed checks on a few slots so tables fill up,
   // with clears, unused actions and fully random fields mixed in.
   task automatic send_random();
      logic [1:0]  act;
      logic [3:0]  slot;
      logic [3:0]  kind;
      logic [31:0] xl, xh, yl, yh, px, py, tmp;
      int pick;
      slot = 4'($urandom);
      kind = 4'($urandom);
      xl = $urandom;
      xh = $urandom;
      yl = $urandom;
      yh = $urandom;
      px = $urandom;
      py = $urandom;
      if ($urandom_range(0, 9) < 8)
         slot = 4'($urandom_range(0, 3));
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         act = ACT_GRANT;
         if ($urandom_range(0, 9) < 8)
            kind = 4'($urandom_range(0, 3));
         case ($urandom_range(0, 3))
            0: begin
               if (xl > xh) begin tmp = xl; xl = xh; xh = tmp; end
               if (yl > yh) begin tmp = yl; yl = yh; yh = tmp; end
            end
            1: begin
               xh = xl + $urandom_range(0, 255);
               yh = yl + $urandom_range(0, 255);
            end
            2: begin
               xl = 32'd0;
               yl = 32'd0;
               xh = 32'hFFFF_FFFF;
               yh = $urandom_range(0, 9) < 5 ? 32'hFFFF_FFFF : yh;
            end
            default: begin
               // empty rectangle: low above high on one or both axes
               if (xl < xh) begin tmp = xl; xl = xh; xh = tmp; end
               if ($urandom_range(0, 1) == 1 && yl < yh) begin
                  tmp = yl; yl = yh; yh = tmp;
               end
            end
         endcase
      end else if (pick < 92) begin
         act = ACT_CHECK;
         case ($urandom_range(0, 3))
            0, 1: begin
               kind = last_kind[slot];
               px = pick_between(last_xl[slot], last_xh[slot]);
               py = pick_between(last_yl[slot], last_yh[slot]);
            end
            2: begin
               kind = last_kind[slot];
               px = $urandom_range(0, 1) ? last_xl[slot] - 32'd1 : last_xh[slot] + 32'd1;
               py = $urandom_range(0, 1) ? last_yl[slot] : last_yh[slot];
               if ($urandom_range(0, 1) == 1) begin
                  tmp = px; px = $urandom_range(0, 1) ? last_xl[slot] : last_xh[slot];
                  py = $urandom_range(0, 1) ? last_yl[slot] - 32'd1 : last_yh[slot] + 32'd1;
               end
            end
            default: ;
         endcase
      end else if (pick < 96) begin
         act = ACT_CLEAR;
      end else begin
         act = ACT_UNUSED;
      end
      send_item(act, slot, kind, xl, xh, yl, yh, px, py);
   endtask

   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0)
         @(posedge clock);
   endtask

   initial begin
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tuser     = ACT_GRANT;
      req_tdata     = '0;
      hold_request  = 1'b0;
      send_idle_pct = 30;
      recv_idle_pct = 30;
      for (int s = 0; s < 16; s++) begin
         last_kind[s] = '0;
         last_xl[s]   = '0;
         last_xh[s]   = '0;
         last_yl[s]   = '0;
         last_yh[s]   = '0;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty table after reset
      send_item(ACT_CHECK, 4'd0, 4'd0, '0, '0, '0, '0, '0, '0);
      // full-plane grant on the top slot and kind, probed at both corners
      send_item(ACT_GRANT, 4'd15, 4'd15, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF,
                '0, '0);
      send_item(ACT_CHECK, 4'd15, 4'd15, '0, '0, '0, '0, 32'd0, 32'd0);
      send_item(ACT_CHECK, 4'd15, 4'd15, '0, '0, '0, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(ACT_CHECK, 4'd15, 4'd14, '0, '0, '0, '0, 32'd5, 32'd5);
      // empty rectangle never matches
      send_item(ACT_GRANT, 4'd1, 4'd0, 32'd10, 32'd9, 32'd0, 32'hFFFF_FFFF, '0, '0);
      send_item(ACT_CHECK, 4'd1, 4'd0, '0, '0, '0, '0, 32'd10, 32'd0);
      // single-point rectangle and its neighbors
      send_item(ACT_GRANT, 4'd3, 4'd5, 32'd100, 32'd100, 32'd100, 32'd100, '0, '0);
      send_item(ACT_CHECK, 4'd3, 4'd5, '0, '0, '0, '0, 32'd100, 32'd100);
      send_item(ACT_CHECK, 4'd3, 4'd5, '0, '0, '0, '0, 32'd101, 32'd100);
      send_item(ACT_CHECK, 4'd3, 4'd5, '0, '0, '0, '0, 32'd100, 32'd99);
      // fill slot 2, then one grant too many
      for (int i = 0; i < 8; i++)
         send_item(ACT_GRANT, 4'd2, 4'(i), 32'(i * 16), 32'(i * 16 + 15),
                   32'd0, 32'hFFFF_FFFF, '0, '0);
      send_item(ACT_GRANT, 4'd2, 4'd9, 32'd0, 32'd1, 32'd0, 32'd1, '0, '0);
      send_item(ACT_CHECK, 4'd2, 4'd7, '0, '0, '0, '0, 32'd127, 32'd12345);
      send_item(ACT_UNUSED, 4'd15, 4'd15, '1, '1, '1, '1, '1, '1);
      // clear leaves stale entries that must not match
      send_item(ACT_CLEAR, 4'd2, 4'd0, '0, '0, '0, '0, '0, '0);
      send_item(ACT_CHECK, 4'd2, 4'd7, '0, '0, '0, '0, 32'd127, 32'd1);
      send_item(ACT_GRANT, 4'd2, 4'd7, 32'd0, 32'd0, 32'd0, 32'd0, '0, '0);
      send_item(ACT_CHECK, 4'd2, 4'd7, '0, '0, '0, '0, 32'd0, 32'd0);

      for (int n = 0; n < 600; n++)
         send_random();
      wait_for_results();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      for (int n = 0; n < 300; n++)
         send_random();
      wait_for_results();

      send_idle_pct = 30;
      recv_idle_pct = 30;
      hold_request  = 1'b1;
      for (int n = 0; n < 525; n++)
         send_random();

      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("capability_region_checker test passed");
      end else begin
         $display("capability_region_checker test failed");
      end
      $finish;
   end

endmodule
